[sv/mlr_pkg.sv]
// mlr_pkg: shared constants, codes and types of the midpoint line rasterizer
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int ORIGIN_BITS    = 11;
    localparam int PIX_BITS       = 13;
    localparam int COLOR_BITS     = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int M_DATA_BITS    = 32;

    localparam logic [ORIGIN_BITS-1:0] ORIGIN_X_RESET = 11'd320;
    localparam logic [ORIGIN_BITS-1:0] ORIGIN_Y_RESET = 11'd320;

    // register index, taken from paddr[2]
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // slope classes, bit 0 set means steep
    localparam logic [1:0] CLS_SHALLOW_RISE = 2'd0;
    localparam logic [1:0] CLS_STEEP_RISE   = 2'd1;
    localparam logic [1:0] CLS_SHALLOW_FALL = 2'd2;
    localparam logic [1:0] CLS_STEEP_FALL   = 2'd3;

    // screen coordinate width for a given input coordinate width
    function automatic int scr_bits(input int coord_bits);
        scr_bits = ((coord_bits > ORIGIN_BITS) ? coord_bits : ORIGIN_BITS) + 2;
    endfunction

    // queue entry: kind, class, start x, start y, major delta, minor delta, color
    function automatic int entry_bits(input int coord_bits);
        entry_bits = 1 + 2 + 2 * scr_bits(coord_bits) + 2 * coord_bits + COLOR_BITS;
    endfunction

    function automatic int s_data_bits(input int coord_bits);
        s_data_bits = ((4 * coord_bits + COLOR_BITS + 7) / 8) * 8;
    endfunction

    typedef struct packed {
        logic active;
        logic steps_zero;
        logic pop;
    } bk_status_t;

endpackage

`default_nettype wire

[sv/midpoint_line_rasterizer_unit.sv]
// midpoint_line_rasterizer_unit: top level, origin registers and the front/queue/back chain
// depends on mlr_pkg, mlr_front, mlr_queue, mlr_back
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tuser kind, s_tdata endpoints and color
//  m_        out        m_tvalid / m_tready    m_tdata pixel, m_tlast final pixel
//  apb       in         psel, penable, pwrite  origin_x at 0x0, origin_y at 0x4
//
//  one request per clock sustained while m_tready stays high; a pixel shows on m_ once its
//  request has passed the front register, a queue entry and the pixel output register
//  the stepping unit does one add and one sign test per pixel and sets the pace
//  synchronous active-low reset clears control state; the block comes up idle
//  with m_tready low the queue and the front register take three more requests,
//  then s_tready drops
`timescale 1ns / 1ps
`default_nettype none

module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    // apb
    input  wire logic                                        psel,
    input  wire logic                                        penable,
    input  wire logic                                        pwrite,
    input  wire logic [mlr_pkg::APB_ADDR_BITS-1:0]           paddr,
    input  wire logic [mlr_pkg::APB_DATA_BITS-1:0]           pwdata,
    output logic      [mlr_pkg::APB_DATA_BITS-1:0]           prdata,
    output logic                                             pready,
    // input stream
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    // start_x, start_y, end_x, end_y, color, zero fill
    input  wire logic [mlr_pkg::s_data_bits(COORD_BITS)-1:0] s_tdata,
    // kind
    input  wire logic                                        s_tuser,
    // output stream
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic      [mlr_pkg::M_DATA_BITS-1:0]             m_tdata,
    output logic                                             m_tlast
);

    localparam int EW = mlr_pkg::entry_bits(COORD_BITS);
    localparam int OB = mlr_pkg::ORIGIN_BITS;
    localparam int PB = mlr_pkg::PIX_BITS;
    localparam int CB = mlr_pkg::COLOR_BITS;

    logic [OB-1:0] origin_x_reg, origin_y_reg;
    logic          cfg_write;

    logic          fq_valid, fq_ready;
    logic [EW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [EW-1:0] qb_data;

    logic [PB-1:0] px, py;
    logic [CB-1:0] pcolor;
    mlr_pkg::bk_status_t bk_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= mlr_pkg::ORIGIN_X_RESET;
            origin_y_reg <= mlr_pkg::ORIGIN_Y_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                mlr_pkg::CFG_ORIGIN_X: origin_x_reg <= pwdata[OB-1:0];
                mlr_pkg::CFG_ORIGIN_Y: origin_y_reg <= pwdata[OB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mlr_pkg::CFG_ORIGIN_X: prdata = {{(mlr_pkg::APB_DATA_BITS-OB){1'b0}}, origin_x_reg};
            mlr_pkg::CFG_ORIGIN_Y: prdata = {{(mlr_pkg::APB_DATA_BITS-OB){1'b0}}, origin_y_reg};
            default:               prdata = '0;
        endcase
    end

    mlr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    mlr_queue #(
        .WIDTH(EW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    mlr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (px),
        .out_y     (py),
        .out_color (pcolor),
        .out_last  (m_tlast),
        .status    (bk_status)
    );

    assign m_tdata = {{(mlr_pkg::M_DATA_BITS-2*PB-CB){1'b0}}, pcolor, py, px};

    // a running line always has pixels left
    a_active_has_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_status.active |-> !bk_status.steps_zero)
        else $error("active line with no steps left");

    // a new pixel only appears after a request left the queue
    a_result_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(bk_status.pop))
        else $error("pixel appeared without a popped request");

    // the final pixel of a line leaves the stepper idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !bk_status.active)
        else $error("stepper still active while final pixel is shown");

endmodule

`default_nettype wire

[sv/mlr_queue.sv]
// mlr_queue: short request queue between the front and the back
// depends on mlr_pkg for the depth
`timescale 1ns / 1ps
`default_nettype none

module mlr_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int DEPTH    = mlr_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/mlr_front.sv]
// mlr_front: accepts requests, maps endpoints to screen space and classifies the line
// depends on mlr_pkg; feeds mlr_queue
`timescale 1ns / 1ps
`default_nettype none

module mlr_front #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                             aclk,
    input  wire logic                                             aresetn,
    input  wire logic [mlr_pkg::ORIGIN_BITS-1:0]                  origin_x,
    input  wire logic [mlr_pkg::ORIGIN_BITS-1:0]                  origin_y,
    input  wire logic                                             in_valid,
    output logic                                                  in_ready,
    input  wire logic                                             in_kind,
    input  wire logic [mlr_pkg::s_data_bits(COORD_BITS)-1:0]      in_data,
    output logic                                                  q_valid,
    input  wire logic                                             q_ready,
    output logic      [mlr_pkg::entry_bits(COORD_BITS)-1:0]       q_data
);

    localparam int C    = COORD_BITS;
    localparam int SCR  = mlr_pkg::scr_bits(COORD_BITS);
    localparam int CB   = mlr_pkg::COLOR_BITS;
    localparam int OB   = mlr_pkg::ORIGIN_BITS;

    logic [C-1:0]  sx, sy, ex, ey;
    logic [CB-1:0] color;
    logic [SCR-1:0] ox_ext, oy_ext;
    logic [C:0]    dxp, dxn, dyp, dyn;

    // stage register
    logic           p_valid_reg;
    logic           p_kind_reg;
    logic [CB-1:0]  p_color_reg;
    logic [SCR-1:0] p_x1_reg, p_y1_reg, p_x2_reg, p_y2_reg;
    logic [C-1:0]   p_adx_reg, p_ady_reg;
    logic           p_dx_neg_reg, p_dx_zero_reg, p_dy_neg_reg, p_dy_zero_reg;

    logic           dy_pos, same, shallow, steep, swap;
    logic [1:0]     cls;
    logic [SCR-1:0] start_x, start_y;
    logic [C-1:0]   dmaj, dmin;

    assign sx    = in_data[C-1:0];
    assign sy    = in_data[2*C-1:C];
    assign ex    = in_data[3*C-1:2*C];
    assign ey    = in_data[4*C-1:3*C];
    assign color = in_data[4*C+CB-1:4*C];

    assign ox_ext = {{(SCR-OB){1'b0}}, origin_x};
    assign oy_ext = {{(SCR-OB){1'b0}}, origin_y};

    // screen dx = ex - sx, screen dy = sy - ey (row axis points down)
    assign dxp = {ex[C-1], ex} - {sx[C-1], sx};
    assign dxn = {sx[C-1], sx} - {ex[C-1], ex};
    assign dyp = {sy[C-1], sy} - {ey[C-1], ey};
    assign dyn = {ey[C-1], ey} - {sy[C-1], sy};

    assign in_ready = !p_valid_reg || q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (in_ready) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            p_kind_reg    <= in_kind;
            p_color_reg   <= color;
            p_x1_reg      <= ox_ext + {{(SCR-C){sx[C-1]}}, sx};
            p_y1_reg      <= oy_ext - {{(SCR-C){sy[C-1]}}, sy};
            p_x2_reg      <= ox_ext + {{(SCR-C){ex[C-1]}}, ex};
            p_y2_reg      <= oy_ext - {{(SCR-C){ey[C-1]}}, ey};
            p_adx_reg     <= dxp[C] ? dxn[C-1:0] : dxp[C-1:0];
            p_ady_reg     <= dyp[C] ? dyn[C-1:0] : dyp[C-1:0];
            p_dx_neg_reg  <= dxp[C];
            p_dx_zero_reg <= (dxp == '0);
            p_dy_neg_reg  <= dyp[C];
            p_dy_zero_reg <= (dyp == '0);
        end
    end

    // classification
    always_comb begin
        dy_pos  = !p_dy_neg_reg && !p_dy_zero_reg;
        shallow = (p_ady_reg < p_adx_reg);
        same    = p_dy_zero_reg || (!p_dx_neg_reg == dy_pos);
        if (p_dx_zero_reg) begin
            cls = dy_pos ? mlr_pkg::CLS_STEEP_RISE : mlr_pkg::CLS_STEEP_FALL;
        end else if (same) begin
            cls = shallow ? mlr_pkg::CLS_SHALLOW_RISE : mlr_pkg::CLS_STEEP_RISE;
        end else begin
            cls = shallow ? mlr_pkg::CLS_SHALLOW_FALL : mlr_pkg::CLS_STEEP_FALL;
        end
        steep   = cls[0];
        swap    = steep ? p_dy_neg_reg : p_dx_neg_reg;
        start_x = swap ? p_x2_reg : p_x1_reg;
        start_y = swap ? p_y2_reg : p_y1_reg;
        dmaj    = steep ? p_ady_reg : p_adx_reg;
        dmin    = steep ? p_adx_reg : p_ady_reg;
    end

    assign q_valid = p_valid_reg;
    assign q_data  = {p_kind_reg, cls, start_x, start_y, dmaj, dmin, p_color_reg};

endmodule

`default_nettype wire

[sv/mlr_back.sv]
// mlr_back: runs the midpoint stepping and holds the pixel output register
// depends on mlr_pkg; fed by mlr_queue
`timescale 1ns / 1ps
`default_nettype none

module mlr_back #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        q_valid,
    output logic                                             q_ready,
    input  wire logic [mlr_pkg::entry_bits(COORD_BITS)-1:0]  q_data,
    output logic                                             out_valid,
    input  wire logic                                        out_ready,
    output logic      [mlr_pkg::PIX_BITS-1:0]                out_x,
    output logic      [mlr_pkg::PIX_BITS-1:0]                out_y,
    output logic      [mlr_pkg::COLOR_BITS-1:0]              out_color,
    output logic                                             out_last,
    output mlr_pkg::bk_status_t                              status
);

    localparam int C   = COORD_BITS;
    localparam int SCR = mlr_pkg::scr_bits(COORD_BITS);
    localparam int CB  = mlr_pkg::COLOR_BITS;
    localparam int PB  = mlr_pkg::PIX_BITS;
    localparam int DB  = COORD_BITS + 3;

    logic           e_kind;
    logic [1:0]     e_cls;
    logic [SCR-1:0] e_sx, e_sy;
    logic [C-1:0]   e_dmaj, e_dmin;
    logic [CB-1:0]  e_color;

    logic           active_reg, active_next;
    logic [C-1:0]   steps_reg, steps_next;
    logic [1:0]     cls_reg, cls_next;
    logic [SCR-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [DB-1:0]  dec_reg, dec_next;
    logic [DB-1:0]  dec_a_reg, dec_a_next;
    logic [DB-1:0]  dec_b_reg, dec_b_next;
    logic [CB-1:0]  color_reg, color_next;

    logic           out_valid_reg, out_valid_next;
    logic [PB-1:0]  out_x_reg, out_y_reg;
    logic [CB-1:0]  out_color_reg;
    logic           out_last_reg;
    logic           emit;

    logic           pop, minor;

    assign {e_kind, e_cls, e_sx, e_sy, e_dmaj, e_dmin, e_color} = q_data;

    assign q_ready = !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        active_next    = active_reg;
        steps_next     = steps_reg;
        cls_next       = cls_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dec_next       = dec_reg;
        dec_a_next     = dec_a_reg;
        dec_b_next     = dec_b_reg;
        color_next     = color_reg;
        emit           = 1'b0;
        minor          = dec_reg[DB-1] || (cls_reg[0] && (dec_reg == '0));
        out_valid_next = out_valid_reg && !out_ready;

        if (pop) begin
            if (e_kind == mlr_pkg::KIND_LOAD) begin
                cls_next   = e_cls;
                cx_next    = e_sx;
                cy_next    = e_sy;
                steps_next = e_dmaj;
                dec_next   = {3'b000, e_dmaj} - {2'b00, e_dmin, 1'b0};
                dec_a_next = {2'b00, e_dmaj, 1'b0} - {2'b00, e_dmin, 1'b0};
                dec_b_next = {2'b00, e_dmin, 1'b0};
                color_next = e_color;
                emit       = 1'b1;
            end else if (active_reg && (steps_reg != '0)) begin
                dec_next = minor ? dec_reg + dec_a_reg : dec_reg - dec_b_reg;
                case (cls_reg)
                    mlr_pkg::CLS_SHALLOW_RISE: begin
                        cx_next = cx_reg + 1'b1;
                        if (minor) cy_next = cy_reg + 1'b1;
                    end
                    mlr_pkg::CLS_STEEP_RISE: begin
                        cy_next = cy_reg + 1'b1;
                        if (minor) cx_next = cx_reg + 1'b1;
                    end
                    mlr_pkg::CLS_SHALLOW_FALL: begin
                        cx_next = cx_reg + 1'b1;
                        if (minor) cy_next = cy_reg - 1'b1;
                    end
                    default: begin
                        cy_next = cy_reg + 1'b1;
                        if (minor) cx_next = cx_reg - 1'b1;
                    end
                endcase
                steps_next = steps_reg - 1'b1;
                emit       = 1'b1;
            end
            // a step while idle leaves nothing behind
            active_next = emit && (steps_next != '0);
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            steps_reg     <= '0;
            cls_reg       <= mlr_pkg::CLS_SHALLOW_RISE;
            cx_reg        <= '0;
            cy_reg        <= '0;
            dec_reg       <= '0;
            dec_a_reg     <= '0;
            dec_b_reg     <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            steps_reg     <= steps_next;
            cls_reg       <= cls_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            dec_reg       <= dec_next;
            dec_a_reg     <= dec_a_next;
            dec_b_reg     <= dec_b_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg     <= cx_next[PB-1:0];
            out_y_reg     <= cy_next[PB-1:0];
            out_color_reg <= color_next;
            out_last_reg  <= (steps_next == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_color = out_color_reg;
    assign out_last  = out_last_reg;

    assign status.active     = active_reg;
    assign status.steps_zero = (steps_reg == '0);
    assign status.pop        = pop;

endmodule

`default_nettype wire
